/* src/cpp_pkg.sv */
// shared types and constants for the closest point pairs unit
package cpp_pkg;
    localparam int MAX_POINTS = 64;
    localparam int MAX_PAIRS  = 16;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int PIDX_BITS  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int PCNT_BITS  = $clog2(MAX_PAIRS + 1);
    localparam int DIST_BITS  = 2 * COORD_BITS + 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        t_coord           first_x;
        t_coord           first_y;
        t_coord           second_x;
        t_coord           second_y;
        logic [DIST_BITS-1:0] dist_sq;
        logic             pair_valid;
        logic             pairs_dropped;
        logic             last_pair;
    } t_result;

    typedef enum logic [3:0] {
        ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_SORT_WR, ST_SORT_PUT,
        ST_SCAN_RD, ST_SCAN_SUB, ST_SCAN_MUL, ST_SCAN_ACC,
        ST_EMIT_RD, ST_EMIT_RD2, ST_EMIT_SHOW, ST_EMIT_OUT, ST_EMPTY
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;          // store the input point
        logic clear_count;   // end of run
        logic key_load;      // key = store[i]
        logic rd_j1;         // read store[j-1]
        logic shift_wr;      // store[j] = store[j-1]
        logic key_wr;        // store[j] = key
        logic sort_init;     // i = 1, j = 1
        logic sort_next_i;   // i++, j = i
        logic sort_dec_j;    // j--
        logic scan_init;     // i = 0, j = 1, first pair
        logic scan_rd;       // read store[i], store[j]
        logic scan_sub;
        logic scan_mul;
        logic scan_acc;
        logic emit_init;
        logic emit_rd;
        logic emit_rd2;
        logic emit_show;
        logic emit_next;
        logic out_empty;
    } t_cmd;

    // status from the datapath back to the controller
    typedef struct packed {
        logic few;           // fewer than two points stored
        logic sort_done;     // i >= count
        logic key_less;      // key < store[j-1]
        logic j_zero;
        logic scan_last;     // current pair is the last
        logic emit_last;
    } t_status;
endpackage

/* src/cpp_if.sv */
// valid/ready channel carrying one payload beat
interface cpp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/closest_point_pairs_unit.sv */
// top level of the closest point pairs unit
// Points are loaded one per beat (up to 64 kept, later ones dropped). The
// beat marked last starts an insertion sort over the point memory and then
// a scan of all N*(N-1)/2 pairs through the two read ports of the point
// memory and the subtract/square/add pipeline; a set of fewer than two
// points gives one invalid result instead. Each kept tied pair is read
// from the pair memory, then its points are read, then it is loaded into
// the result register and shown until the sink takes it.
// No input is accepted from the last beat until the final result is taken.
module closest_point_pairs_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    cpp_if.sink   in_ch,
    cpp_if.source out_ch
);
    cpp_pkg::t_cmd    w_cmd_raw, w_cmd;
    cpp_pkg::t_status w_status;
    cpp_pkg::t_point  w_point;
    cpp_pkg::t_result w_result;

    assign w_point.x = in_ch.data.px;
    assign w_point.y = in_ch.data.py;

    cpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_last   (in_ch.data.last_point),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd_raw)
    );

    cpp_show u_show (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_raw),
        .o_cmd   (w_cmd)
    );

    cpp_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_point  (w_point),
        .o_status (w_status),
        .o_result (w_result)
    );

    assign out_ch.data = w_result;
endmodule

/* src/cpp_datapath.sv */
// point store, sorter, pair scanner and result register
module cpp_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpp_pkg::t_cmd     i_cmd,
    input  cpp_pkg::t_point   i_point,
    output cpp_pkg::t_status  o_status,
    output cpp_pkg::t_result  o_result
);
    localparam int D = cpp_pkg::DIST_BITS;

    cpp_pkg::t_point r_mem [cpp_pkg::MAX_POINTS];
    logic [2*cpp_pkg::IDX_BITS-1:0] r_pmem [cpp_pkg::MAX_PAIRS];

    logic [cpp_pkg::CNT_BITS-1:0]  r_count;
    logic [cpp_pkg::CNT_BITS-1:0]  r_i, r_j;
    cpp_pkg::t_point               r_key, r_rd_a, r_rd_b;
    logic [cpp_pkg::DIFF_BITS-1:0] r_dx, r_dy;
    logic [D-2:0]                  r_sx, r_sy;
    logic [D-1:0]                  r_best;
    logic                          r_first;
    logic [cpp_pkg::PCNT_BITS-1:0] r_pcnt, r_pk;
    logic                          r_ovf;
    logic [2*cpp_pkg::IDX_BITS-1:0] r_prd;
    cpp_pkg::t_result              r_res;

    logic [cpp_pkg::IDX_BITS-1:0] w_jm1;
    logic [D-1:0]                 w_d;
    logic signed [cpp_pkg::DIFF_BITS-1:0] w_ddx, w_ddy;

    assign w_jm1 = cpp_pkg::IDX_BITS'(r_j - 1'b1);
    assign w_d   = {1'b0, r_sx} + {1'b0, r_sy};
    assign w_ddx = cpp_pkg::DIFF_BITS'(r_rd_a.x) - cpp_pkg::DIFF_BITS'(r_rd_b.x);
    assign w_ddy = cpp_pkg::DIFF_BITS'(r_rd_a.y) - cpp_pkg::DIFF_BITS'(r_rd_b.y);

    // point memory, one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count < cpp_pkg::CNT_BITS'(cpp_pkg::MAX_POINTS))
            r_mem[r_count[cpp_pkg::IDX_BITS-1:0]] <= i_point;
        else if (i_cmd.shift_wr)
            r_mem[r_j[cpp_pkg::IDX_BITS-1:0]] <= r_rd_b;
        else if (i_cmd.key_wr)
            r_mem[r_j[cpp_pkg::IDX_BITS-1:0]] <= r_key;
        if (i_cmd.rd_j1)
            r_rd_b <= r_mem[w_jm1];
        else if (i_cmd.scan_rd)
            r_rd_b <= r_mem[r_j[cpp_pkg::IDX_BITS-1:0]];
        else if (i_cmd.emit_rd)
            r_rd_b <= r_mem[r_prd[cpp_pkg::IDX_BITS-1:0]];
        if (i_cmd.key_load)
            r_key <= r_mem[r_i[cpp_pkg::IDX_BITS-1:0]];
        else if (i_cmd.scan_rd)
            r_rd_a <= r_mem[r_i[cpp_pkg::IDX_BITS-1:0]];
        else if (i_cmd.emit_rd)
            r_rd_a <= r_mem[r_prd[2*cpp_pkg::IDX_BITS-1:cpp_pkg::IDX_BITS]];
    end

    // point count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_count <= '0;
        else if (i_cmd.clear_count)
            r_count <= '0;
        else if (i_cmd.load && r_count < cpp_pkg::CNT_BITS'(cpp_pkg::MAX_POINTS))
            r_count <= r_count + 1'b1;
    end

    // loop indices
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init) begin
            r_i <= cpp_pkg::CNT_BITS'(1);
            r_j <= cpp_pkg::CNT_BITS'(1);
        end else if (i_cmd.sort_next_i) begin
            r_i <= r_i + 1'b1;
            r_j <= r_i + 1'b1;
        end else if (i_cmd.sort_dec_j) begin
            r_j <= r_j - 1'b1;
        end else if (i_cmd.scan_init) begin
            r_i <= '0;
            r_j <= cpp_pkg::CNT_BITS'(1);
        end else if (i_cmd.scan_acc) begin
            if (r_j + 1'b1 >= r_count) begin
                r_i <= r_i + 1'b1;
                r_j <= r_i + 2'd2;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    // squared distance pipeline: subtract, square, add
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_sub) begin
            r_dx <= w_ddx[cpp_pkg::DIFF_BITS-1] ? cpp_pkg::DIFF_BITS'(-w_ddx)
                                                : w_ddx;
            r_dy <= w_ddy[cpp_pkg::DIFF_BITS-1] ? cpp_pkg::DIFF_BITS'(-w_ddy)
                                                : w_ddy;
        end
        if (i_cmd.scan_mul) begin
            r_sx <= (D-1)'(r_dx) * (D-1)'(r_dx);
            r_sy <= (D-1)'(r_dy) * (D-1)'(r_dy);
        end
    end

    // best distance and tied pair list
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_first <= 1'b1;
            r_pcnt  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.scan_acc) begin
            r_first <= 1'b0;
            if (r_first || w_d < r_best) begin
                r_best  <= w_d;
                r_pmem[0] <= {r_i[cpp_pkg::IDX_BITS-1:0], r_j[cpp_pkg::IDX_BITS-1:0]};
                r_pcnt  <= cpp_pkg::PCNT_BITS'(1);
                r_ovf   <= 1'b0;
            end else if (w_d == r_best) begin
                if (r_pcnt < cpp_pkg::PCNT_BITS'(cpp_pkg::MAX_PAIRS)) begin
                    r_pmem[r_pcnt[cpp_pkg::PIDX_BITS-1:0]] <=
                        {r_i[cpp_pkg::IDX_BITS-1:0], r_j[cpp_pkg::IDX_BITS-1:0]};
                    r_pcnt <= r_pcnt + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    // emission index and pair read
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_init)
            r_pk <= '0;
        else if (i_cmd.emit_next)
            r_pk <= r_pk + 1'b1;
        if (i_cmd.emit_rd2)
            r_prd <= r_pmem[r_pk[cpp_pkg::PIDX_BITS-1:0]];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_empty) begin
            r_res <= '{last_pair: 1'b1, default: '0};
        end else if (i_cmd.emit_show) begin
            r_res.first_x       <= r_rd_a.x;
            r_res.first_y       <= r_rd_a.y;
            r_res.second_x      <= r_rd_b.x;
            r_res.second_y      <= r_rd_b.y;
            r_res.dist_sq       <= r_best;
            r_res.pair_valid    <= 1'b1;
            r_res.pairs_dropped <= r_ovf;
            r_res.last_pair     <= (r_pk + 1'b1 == r_pcnt);
        end
    end

    always_comb begin
        o_status.few       = (r_count < cpp_pkg::CNT_BITS'(2));
        o_status.sort_done = (r_i >= r_count);
        o_status.key_less  = (r_key.x < r_rd_b.x) ||
                             (r_key.x == r_rd_b.x && r_key.y < r_rd_b.y);
        o_status.j_zero    = (r_j == '0);
        o_status.scan_last = (r_j + 1'b1 >= r_count) && (r_i + 2'd2 >= r_count);
        o_status.emit_last = (r_pk + 1'b1 == r_pcnt);
    end

    assign o_result = r_res;
endmodule

/* src/cpp_ctrl.sv */
// sequencer for load, insertion sort, pair scan and emission
module cpp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  cpp_pkg::t_status i_status,
    output cpp_pkg::t_cmd    o_cmd
);
    cpp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= cpp_pkg::ST_LOAD;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            cpp_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.sort_init = 1'b1;
                        n_state = cpp_pkg::ST_SORT_RD;
                    end
                end
            end
            cpp_pkg::ST_SORT_RD: begin
                if (i_status.few) begin
                    o_cmd.out_empty = 1'b1;
                    n_state = cpp_pkg::ST_EMPTY;
                end else if (i_status.sort_done) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = cpp_pkg::ST_SCAN_RD;
                end else begin
                    o_cmd.key_load = 1'b1;
                    o_cmd.rd_j1    = 1'b1;
                    n_state = cpp_pkg::ST_SORT_CMP;
                end
            end
            cpp_pkg::ST_SORT_CMP: begin
                if (i_status.key_less) begin
                    o_cmd.shift_wr   = 1'b1;
                    o_cmd.sort_dec_j = 1'b1;
                    n_state = cpp_pkg::ST_SORT_WR;
                end else begin
                    n_state = cpp_pkg::ST_SORT_PUT;
                end
            end
            cpp_pkg::ST_SORT_WR: begin
                if (i_status.j_zero) begin
                    n_state = cpp_pkg::ST_SORT_PUT;
                end else begin
                    o_cmd.rd_j1 = 1'b1;
                    n_state = cpp_pkg::ST_SORT_CMP;
                end
            end
            cpp_pkg::ST_SORT_PUT: begin
                o_cmd.key_wr      = 1'b1;
                o_cmd.sort_next_i = 1'b1;
                n_state = cpp_pkg::ST_SORT_RD;
            end
            cpp_pkg::ST_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = cpp_pkg::ST_SCAN_SUB;
            end
            cpp_pkg::ST_SCAN_SUB: begin
                o_cmd.scan_sub = 1'b1;
                n_state = cpp_pkg::ST_SCAN_MUL;
            end
            cpp_pkg::ST_SCAN_MUL: begin
                o_cmd.scan_mul = 1'b1;
                n_state = cpp_pkg::ST_SCAN_ACC;
            end
            cpp_pkg::ST_SCAN_ACC: begin
                o_cmd.scan_acc = 1'b1;
                if (i_status.scan_last) begin
                    o_cmd.emit_init = 1'b1;
                    n_state = cpp_pkg::ST_EMIT_RD2;
                end else begin
                    n_state = cpp_pkg::ST_SCAN_RD;
                end
            end
            cpp_pkg::ST_EMIT_RD2: begin
                o_cmd.emit_rd2 = 1'b1;
                n_state = cpp_pkg::ST_EMIT_RD;
            end
            cpp_pkg::ST_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state = cpp_pkg::ST_EMIT_SHOW;
            end
            cpp_pkg::ST_EMIT_SHOW: begin
                // result register loads here from the delayed read command
                n_state = cpp_pkg::ST_EMIT_OUT;
            end
            cpp_pkg::ST_EMIT_OUT: begin
                // result stays until taken
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.emit_last) begin
                        o_cmd.clear_count = 1'b1;
                        n_state = cpp_pkg::ST_LOAD;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state = cpp_pkg::ST_EMIT_RD2;
                    end
                end
            end
            cpp_pkg::ST_EMPTY: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.clear_count = 1'b1;
                    n_state = cpp_pkg::ST_LOAD;
                end
            end
            default: n_state = cpp_pkg::ST_LOAD;
        endcase
    end
endmodule

/* src/cpp_show.sv */
// registered delay that issues the result register load in the cycle after the pair read
module cpp_show (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cpp_pkg::t_cmd i_cmd,
    output cpp_pkg::t_cmd o_cmd
);
    logic r_show;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_show <= 1'b0;
        else          r_show <= i_cmd.emit_rd;
    end

    always_comb begin
        o_cmd           = i_cmd;
        o_cmd.emit_show = r_show;
    end
endmodule

/* src/cpp_checker.sv */
// port-level checks for the closest point pairs unit
module cpp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_pair_valid,
    input logic i_out_last_pair
);
    // no input taken while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("input ready during output");
    // last beat closes the load phase
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("ready after last point");
    // an invalid result is always the last one
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_pair_valid) |-> i_out_last_pair)
        else $error("invalid result not last");
    // held result stays valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid) else $error("output dropped");
endmodule

bind closest_point_pairs_unit cpp_checker u_cpp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (in_ch.valid),
    .i_in_ready       (in_ch.ready),
    .i_in_last        (in_ch.data.last_point),
    .i_out_valid      (out_ch.valid),
    .i_out_ready      (out_ch.ready),
    .i_out_pair_valid (out_ch.data.pair_valid),
    .i_out_last_pair  (out_ch.data.last_pair)
);

/* dv/tb_closest_point_pairs_unit.sv */
// testbench for the closest point pairs unit: directed table plus random point sets
`timescale 1ns / 1ps

module tb_closest_point_pairs_unit;
    localparam int  HALF_PERIOD = 6;
    localparam int  NUM_ITEMS   = 500;
    localparam int  DRAIN_WAIT  = 40;
    localparam longint CYCLE_LIMIT = 3000000;

    // one input beat: a point and the end-of-set marker
    typedef struct packed {
        cpp_pkg::t_coord px;
        cpp_pkg::t_coord py;
        logic            last_point;
    } t_point_beat;

    // one row of the directed table
    typedef struct {
        int               x;
        int               y;
        bit               last;
        bit               typed;
        cpp_pkg::t_result res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    cpp_if #(.T(t_point_beat))      in_ch ();
    cpp_if #(.T(cpp_pkg::t_result)) out_ch ();

    closest_point_pairs_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // point set held by the predictor
    cpp_pkg::t_coord set_x [cpp_pkg::MAX_POINTS];
    cpp_pkg::t_coord set_y [cpp_pkg::MAX_POINTS];
    int              set_count;

    cpp_pkg::t_result pending_pairs [$];
    int      errors = 0;
    longint  cycles = 0;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      items_sent;
    t_row    rows [$];

    // clock
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint sq_len(cpp_pkg::t_coord ax, cpp_pkg::t_coord ay,
                                      cpp_pkg::t_coord bx, cpp_pkg::t_coord by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    // load one point; on the end marker sort, scan all pairs and queue the closest ones
    function automatic void predict_closest(t_point_beat b);
        cpp_pkg::t_coord  kx;
        cpp_pkg::t_coord  ky;
        int               j;
        longint           best;
        longint           d;
        int               fi [cpp_pkg::MAX_PAIRS];
        int               si [cpp_pkg::MAX_PAIRS];
        int               kept;
        bit               dropped;
        cpp_pkg::t_result r;
        if (set_count < cpp_pkg::MAX_POINTS) begin
            set_x[set_count] = b.px;
            set_y[set_count] = b.py;
            set_count++;
        end
        if (!b.last_point) return;
        if (set_count < 2) begin
            r = '0;
            r.last_pair = 1'b1;
            pending_pairs.insert(pending_pairs.size(), r);
            set_count = 0;
            return;
        end
        // insertion sort by x then y
        for (int i = 1; i < set_count; i++) begin
            kx = set_x[i];
            ky = set_y[i];
            j = i;
            while (j > 0 && (kx < set_x[j-1] || (kx == set_x[j-1] && ky < set_y[j-1]))) begin
                set_x[j] = set_x[j-1];
                set_y[j] = set_y[j-1];
                j--;
            end
            set_x[j] = kx;
            set_y[j] = ky;
        end
        // all-pairs scan keeping ties in scan order up to the pair store size, flagging the rest as dropped
        best = sq_len(set_x[0], set_y[0], set_x[1], set_y[1]);
        kept = 0;
        dropped = 0;
        for (int a = 0; a + 1 < set_count; a++) begin
            for (int c = a + 1; c < set_count; c++) begin
                d = sq_len(set_x[a], set_y[a], set_x[c], set_y[c]);
                if (d < best) begin
                    best = d;
                    kept = 0;
                    dropped = 0;
                end
                if (d == best) begin
                    if (kept < cpp_pkg::MAX_PAIRS) begin
                        fi[kept] = a;
                        si[kept] = c;
                        kept++;
                    end else begin
                        dropped = 1;
                    end
                end
            end
        end
        for (int k = 0; k < kept; k++) begin
            r.first_x       = set_x[fi[k]];
            r.first_y       = set_y[fi[k]];
            r.second_x      = set_x[si[k]];
            r.second_y      = set_y[si[k]];
            r.dist_sq       = best[cpp_pkg::DIST_BITS-1:0];
            r.pair_valid    = 1'b1;
            r.pairs_dropped = dropped;
            r.last_pair     = (k + 1 == kept);
            pending_pairs.insert(pending_pairs.size(), r);
        end
        set_count = 0;
    endfunction

    // drive one beat at the falling edge and hold it until taken
    task automatic send_point(int x, int y, bit last, bit typed, cpp_pkg::t_result res);
        t_point_beat b;
        b.px = cpp_pkg::t_coord'(x);
        b.py = cpp_pkg::t_coord'(y);
        b.last_point = last;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.data  = b;
        do @(posedge i_clk); while (!in_ch.ready);
        if (typed) begin
            predict_closest(b);
            pending_pairs.delete(pending_pairs.size() - 1);
            pending_pairs.insert(pending_pairs.size(), res);
        end else begin
            predict_closest(b);
        end
        items_sent++;
        if (items_sent == NUM_ITEMS / 3) begin
            send_idle_pct = 64;
            recv_idle_pct = 23;
        end else if (items_sent == 2 * NUM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic send_rand(int x, int y, bit last);
        send_point(x, y, last, 1'b0, '0);
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result check
    always @(posedge i_clk) begin
        cpp_pkg::t_result e;
        cpp_pkg::t_result a;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.data;
            if (pending_pairs.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, a);
                errors++;
            end else begin
                e = pending_pairs.pop_front();
                if (a.first_x !== e.first_x)
                    $display("%0t: first_x exp %0d got %0d", $time, e.first_x, a.first_x);
                if (a.first_y !== e.first_y)
                    $display("%0t: first_y exp %0d got %0d", $time, e.first_y, a.first_y);
                if (a.second_x !== e.second_x)
                    $display("%0t: second_x exp %0d got %0d", $time, e.second_x, a.second_x);
                if (a.second_y !== e.second_y)
                    $display("%0t: second_y exp %0d got %0d", $time, e.second_y, a.second_y);
                if (a.dist_sq !== e.dist_sq)
                    $display("%0t: dist_sq exp %0d got %0d", $time, e.dist_sq, a.dist_sq);
                if (a.pair_valid !== e.pair_valid)
                    $display("%0t: pair_valid exp %0b got %0b", $time, e.pair_valid,
                             a.pair_valid);
                if (a.pairs_dropped !== e.pairs_dropped)
                    $display("%0t: pairs_dropped exp %0b got %0b", $time, e.pairs_dropped,
                             a.pairs_dropped);
                if (a.last_pair !== e.last_pair)
                    $display("%0t: last_pair exp %0b got %0b", $time, e.last_pair,
                             a.last_pair);
                if (a !== e) errors++;
            end
        end
    end

    function automatic cpp_pkg::t_result typed_res(int fx, int fy, int sx, int sy, longint d,
                                                   bit pv, bit pd, bit lp);
        cpp_pkg::t_result r;
        r.first_x = cpp_pkg::t_coord'(fx);
        r.first_y = cpp_pkg::t_coord'(fy);
        r.second_x = cpp_pkg::t_coord'(sx);
        r.second_y = cpp_pkg::t_coord'(sy);
        r.dist_sq = d[cpp_pkg::DIST_BITS-1:0];
        r.pair_valid = pv;
        r.pairs_dropped = pd;
        r.last_pair = lp;
        return r;
    endfunction

    function automatic void add_row(int x, int y, bit last, bit typed,
                                    cpp_pkg::t_result res);
        t_row w;
        w.x = x;
        w.y = y;
        w.last = last;
        w.typed = typed;
        w.res = res;
        rows.insert(rows.size(), w);
    endfunction

    // main sequence
    initial begin
        int kind;
        int n;
        int bx;
        int by;
        int step;
        bit big_done;
        set_count = 0;
        items_sent = 0;
        send_idle_pct = 23;
        recv_idle_pct = 64;
        big_done = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        // lone point: invalid marker result
        add_row(5, -7, 1, 1, typed_res(0, 0, 0, 0, 0, 0, 0, 1));
        // opposite corners: largest distance
        add_row(32767, 32767, 0, 0, '0);
        add_row(-32768, -32768, 1, 1,
                typed_res(-32768, -32768, 32767, 32767, 64'd8589672450, 1, 0, 1));
        // duplicates give distance zero
        add_row(100, 200, 0, 0, '0);
        add_row(100, 200, 0, 0, '0);
        add_row(-3, 9, 1, 0, '0);
        // two-way tie, given out of order
        add_row(2, 0, 0, 0, '0);
        add_row(0, 0, 0, 0, '0);
        add_row(1, 0, 1, 0, '0);
        // same x, sort by signed y
        add_row(-32768, 32767, 0, 0, '0);
        add_row(-32768, -32768, 0, 0, '0);
        add_row(-32768, 0, 1, 0, '0);
        // strictly closer pair found later clears ties
        add_row(0, 0, 0, 0, '0);
        add_row(10, 0, 0, 0, '0);
        add_row(20, 0, 0, 0, '0);
        add_row(21, 0, 1, 0, '0);
        foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].last, rows[i].typed,
                                     rows[i].res);

        // random point sets
        while (items_sent < NUM_ITEMS) begin
            kind = $urandom_range(9);
            if (!big_done && items_sent > NUM_ITEMS / 2) begin
                // overfull set: saturation
                big_done = 1;
                for (int i = 0; i < cpp_pkg::MAX_POINTS + 6; i++)
                    send_rand($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                              i == cpp_pkg::MAX_POINTS + 5);
            end else if (kind <= 4) begin
                n = $urandom_range(8, 2);
                for (int i = 0; i < n; i++)
                    send_rand($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                              i == n - 1);
            end else if (kind <= 7) begin
                // tight cluster for ties and duplicates
                n = $urandom_range(10, 2);
                bx = $urandom_range(65535) - 32768;
                by = $urandom_range(65535) - 32768;
                for (int i = 0; i < n; i++)
                    send_rand(bx + $urandom_range(3), by + $urandom_range(3), i == n - 1);
            end else if (kind == 8) begin
                // evenly spaced points along two rays from one corner: can give more ties than the pair store holds
                n = $urandom_range(22, 15);
                step = $urandom_range(50, 1);
                bx = $urandom_range(2000) - 1000;
                by = $urandom_range(2000) - 1000;
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(1)) send_rand(bx + i * step, by, i == n - 1);
                    else send_rand(bx, by - i * step, i == n - 1);
                end
            end else begin
                send_rand($urandom_range(65535) - 32768, $urandom_range(65535) - 32768, 1);
            end
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;

        // drain
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* filelist.f */
src/cpp_pkg.sv
src/cpp_if.sv
src/cpp_datapath.sv
src/cpp_ctrl.sv
src/cpp_show.sv
src/closest_point_pairs_unit.sv
src/cpp_checker.sv
dv/tb_closest_point_pairs_unit.sv
